### rtl/core/cfwo_pkg.sv
// Shared types and constants of the circular FIFO with overwrite.
package cfwo_pkg;

   localparam int DEPTH  = 256;
   localparam int IDX_W  = 8;
   localparam int LEN_W  = 9;
   localparam int UNIT_W = 8;
   localparam int ADDR_W = 2;
   localparam int DATA_W = 32;

   localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(DEPTH);
   localparam logic [ADDR_W-1:0] REG_QLEN = '0;

   localparam logic [2:0] FUNC_PUSH  = 3'd0;
   localparam logic [2:0] FUNC_OVER  = 3'd1;
   localparam logic [2:0] FUNC_POP   = 3'd2;
   localparam logic [2:0] FUNC_PEEK  = 3'd3;
   localparam logic [2:0] FUNC_SKIP  = 3'd4;
   localparam logic [2:0] FUNC_CLEAR = 3'd5;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [2:0]        func;
      logic [UNIT_W-1:0] unit_data;
      logic [LEN_W-1:0]  unit_count;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [UNIT_W-1:0] read_data;
      logic [LEN_W-1:0]  units_skipped;
      logic [LEN_W-1:0]  usage_count;
      logic              is_empty;
      logic              is_full;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic             clear;
   } csr_type;

   typedef struct packed {
      logic              re;
      logic [IDX_W-1:0]  raddr;
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [UNIT_W-1:0] wdata;
   } ram_req_type;

endpackage

### rtl/core/cfwo_ram.sv
// Unit store: one write port, one registered read port.
module cfwo_ram
   import cfwo_pkg::*;
(
   input  logic              clock,
   input  ram_req_type       ram_req,
   output logic [UNIT_W-1:0] rd_data
);

   logic [UNIT_W-1:0] store_ff [DEPTH];
   logic [UNIT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         store_ff[ram_req.waddr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rd_data_ff <= store_ff[ram_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/cfwo_csr.sv
// Queue length register behind the APB-style port.
module cfwo_csr
   import cfwo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output csr_type           csr
);

   logic [LEN_W-1:0] qlen_ff;
   logic [LEN_W-1:0] qlen_in;
   logic             wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr == REG_QLEN);
   assign qlen_in = wr_hit ? pwdata[LEN_W-1:0] : qlen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         qlen_ff <= LEN_MAX;
      end else begin
         qlen_ff <= qlen_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == REG_QLEN) begin
         prdata = {{(DATA_W-LEN_W){1'b0}}, qlen_ff};
      end
   end

   always_comb begin
      csr.clear = wr_hit;
      if (qlen_ff == '0) begin
         csr.len = LEN_W'(1);
      end else if (qlen_ff > LEN_MAX) begin
         csr.len = LEN_MAX;
      end else begin
         csr.len = qlen_ff;
      end
   end

endmodule

### rtl/core/cfwo_ctrl.sv
// Sequencer: index and count update around the unit store, result register.
module cfwo_ctrl
   import cfwo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_item,
   output logic              rsp_strobe,
   output rsp_type           rsp_item,
   input  csr_type           csr,
   output ram_req_type       ram_req,
   input  logic [UNIT_W-1:0] ram_rd_data
);

   function automatic logic [IDX_W-1:0] idx_advance(
      input logic [IDX_W-1:0] idx,
      input logic [LEN_W-1:0] n,
      input logic [LEN_W-1:0] len
   );
      logic [LEN_W:0] v;
      v = {2'b00, idx} + {1'b0, n};
      if (v >= {1'b0, len}) begin
         v = v - {1'b0, len};
      end
      if (v >= {1'b0, len}) begin
         v = '0;
      end
      return v[IDX_W-1:0];
   endfunction

   state_type        state_ff, state_in;
   req_type          req_ff;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [LEN_W-1:0] count_ff, count_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_strobe_ff;
   logic             accept;
   logic             exec;
   logic             full;
   logic             empty;
   logic [LEN_W-1:0] skipped;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy   = 1'b0;
      accept = 1'b0;
      exec   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            accept = start;
         end
         ST_EXEC: begin
            busy = 1'b1;
            exec = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   assign full  = (count_ff == csr.len);
   assign empty = (count_ff == '0);
   assign skipped = (req_ff.unit_count > count_ff) ? count_ff : req_ff.unit_count;

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      rsp_in    = '0;
      ram_req.re    = accept;
      ram_req.raddr = rd_idx_ff;
      ram_req.we    = 1'b0;
      ram_req.waddr = wr_idx_ff;
      ram_req.wdata = req_ff.unit_data;
      rsp_in.status = STAT_OK;
      if (csr.clear) begin
         wr_idx_in = '0;
         rd_idx_in = '0;
         count_in  = '0;
      end else if (exec) begin
         case (req_ff.func) inside
            FUNC_PUSH: begin
               if (full) begin
                  rsp_in.status = STAT_FULL;
               end else begin
                  ram_req.we = 1'b1;
                  wr_idx_in  = idx_advance(wr_idx_ff, LEN_W'(1), csr.len);
                  count_in   = count_ff + LEN_W'(1);
               end
            end
            FUNC_OVER: begin
               ram_req.we = 1'b1;
               wr_idx_in  = idx_advance(wr_idx_ff, LEN_W'(1), csr.len);
               if (full) begin
                  rd_idx_in = wr_idx_in;
               end else begin
                  count_in = count_ff + LEN_W'(1);
               end
            end
            FUNC_POP, FUNC_PEEK: begin
               if (empty) begin
                  rsp_in.status = STAT_EMPTY;
               end else begin
                  rsp_in.read_data = ram_rd_data;
                  if (req_ff.func == FUNC_POP) begin
                     rd_idx_in = idx_advance(rd_idx_ff, LEN_W'(1), csr.len);
                     count_in  = count_ff - LEN_W'(1);
                  end
               end
            end
            FUNC_SKIP: begin
               rsp_in.units_skipped = skipped;
               rd_idx_in = idx_advance(rd_idx_ff, skipped, csr.len);
               count_in  = count_ff - skipped;
            end
            FUNC_CLEAR: begin
               wr_idx_in = '0;
               rd_idx_in = '0;
               count_in  = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
      rsp_in.usage_count = count_in;
      rsp_in.is_empty    = (count_in == '0);
      rsp_in.is_full     = (count_in == csr.len);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_idx_ff     <= wr_idx_in;
         rd_idx_ff     <= rd_idx_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= exec;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

### rtl/core/circular_fifo_with_overwrite_top.sv
// Top level of the circular FIFO with overwrite.
//
// Request channel: drive req_item and raise start; the request is taken at
// a rising edge where start is high and busy is low. Operations are push,
// overwrite push, pop, peek, skip and clear.
// Response channel: rsp_item is valid for exactly one cycle while
// rsp_strobe is high; the receiver cannot stall it.
// Sequence: the request is taken in ST_IDLE and executed in ST_EXEC, and
// rsp_strobe and rsp_item are registered at the end of ST_EXEC.
// A new request is not taken while busy. The unit store has a registered
// read, so the oldest unit is read as the request is taken in ST_IDLE and
// ST_EXEC updates indexes, count and store; busy is high during ST_EXEC.
// A new request may be taken while the previous response is on the ports.
// Configuration: queue_length at byte address 0 (reset 256); writing it
// empties the queue. Write only while idle. pready is always high.
// Reset: synchronous, active high; the queue comes up empty and no clearing
// pass over the store is needed.
module circular_fifo_with_overwrite_top
   import cfwo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_item,
   output logic              rsp_strobe,
   output rsp_type           rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   csr_type           csr;
   ram_req_type       ram_req;
   logic [UNIT_W-1:0] ram_rd_data;

   cfwo_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .csr     (csr)
   );

   cfwo_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   cfwo_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .csr         (csr),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data)
   );

endmodule

### rtl/core/cfwo_checker.sv
// Port-level checks of the circular FIFO with overwrite, and their binding.
module cfwo_checker
   import cfwo_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_strobe)
      else $error("request without response two cycles later");

   assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held for more than one cycle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && !$past(rsp_strobe))
      else $error("response strobe out of sequence");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.is_empty == (rsp_item.usage_count == '0)) &&
                     !(rsp_item.is_empty && rsp_item.is_full))
      else $error("response flags disagree with usage");

endmodule

bind circular_fifo_with_overwrite_top cfwo_checker u_cfwo_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
